[src/eps_pkg.sv]
// Shared constants and types for the encoder pulse speed meter.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package eps_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int TICK_BITS   = 24;
    localparam int WINDOW_BITS = 24;
    localparam int SCALE_BITS  = 32;
    localparam int PULSES_BITS = 16;
    localparam int RPS_BITS    = 32;
    localparam int RPM_BITS    = 40;
    localparam int PROD_BITS   = COUNT_BITS + SCALE_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic
    {
        REG_WINDOW_TICKS = 1'b0,
        REG_SPEED_SCALE  = 1'b1
    } reg_index_t;

    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [TICK_BITS-1:0]   tick_t;
    typedef logic [WINDOW_BITS-1:0] window_t;
    typedef logic [SCALE_BITS-1:0]  scale_t;

    // one closed window, handed from the front part to the queue
    typedef struct packed
    {
        logic   valid;
        count_t pulses;
    } window_beat_t;

    // queue status seen by its neighbors
    typedef struct packed
    {
        logic   full;
        logic   empty;
        count_t head;
    } queue_status_t;

endpackage
`default_nettype wire

[src/eps_if.sv]
// Stream interfaces for encoder samples and speed results.
// Depends on eps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface eps_sample_if;
    logic valid;
    logic ready;
    logic level_a;
    logic level_b;

    modport source (output valid, output level_a, output level_b, input ready);
    modport sink   (input valid, input level_a, input level_b, output ready);
endinterface

interface eps_result_if;
    logic                              valid;
    logic                              ready;
    logic [eps_pkg::PULSES_BITS-1:0]   window_pulses;
    logic [eps_pkg::RPS_BITS-1:0]      rev_per_sec;
    logic [eps_pkg::RPM_BITS-1:0]      rev_per_min;

    modport source (output valid, output window_pulses, output rev_per_sec,
                    output rev_per_min, input ready);
    modport sink   (input valid, input window_pulses, input rev_per_sec,
                    input rev_per_min, output ready);
endinterface
`default_nettype wire

[src/eps_front.sv]
// Front part: edge qualification, pulse and tick counting, window close.
// Depends on eps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eps_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  beat,
    input  wire logic                  level_a,
    input  wire logic                  level_b,
    input  wire eps_pkg::window_t      window_ticks,
    output eps_pkg::window_beat_t      push
);
    import eps_pkg::*;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam tick_t  TICK_MAX  = {TICK_BITS{1'b1}};

    logic   prev_a_reg, prev_b_reg, primed_reg, armed_a_reg, armed_b_reg;
    logic   prev_a_next, prev_b_next, primed_next, armed_a_next, armed_b_next;
    count_t pulse_reg, pulse_next, pulse_sum;
    tick_t  tick_reg, tick_next, tick_inc;
    logic   hit_a, hit_b, close;
    logic [COUNT_BITS+1:0] wide_sum;
    logic [WINDOW_BITS-1:0] limit;

    always_comb
    begin
        armed_a_next = armed_a_reg;
        armed_b_next = armed_b_reg;
        hit_a = 1'b0;
        hit_b = 1'b0;
        if (primed_reg)
        begin
            if (!prev_a_reg && level_a)
                armed_a_next = 1'b1;
            else if (prev_a_reg && !level_a && armed_a_reg)
            begin
                hit_a = 1'b1;
                armed_a_next = 1'b0;
            end
            if (prev_b_reg && !level_b)
                armed_b_next = 1'b1;
            else if (!prev_b_reg && level_b && armed_b_reg)
            begin
                hit_b = 1'b1;
                armed_b_next = 1'b0;
            end
        end
        prev_a_next = level_a;
        prev_b_next = level_b;
        primed_next = 1'b1;

        // saturate at full scale; two hits in one sample add two
        wide_sum = {2'b00, pulse_reg} + {{(COUNT_BITS+1){1'b0}}, hit_a}
                   + {{(COUNT_BITS+1){1'b0}}, hit_b};
        pulse_sum = (wide_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : wide_sum[COUNT_BITS-1:0];

        tick_inc = (tick_reg != TICK_MAX) ? tick_reg + 1'b1 : tick_reg;
        limit = (window_ticks == '0) ? WINDOW_BITS'(1) : window_ticks;
        close = ({{WINDOW_BITS{1'b0}}, tick_inc} >= {{TICK_BITS{1'b0}}, limit})
                || (tick_inc == TICK_MAX);

        pulse_next = close ? '0 : pulse_sum;
        tick_next  = close ? '0 : tick_inc;

        push.valid  = beat && close;
        push.pulses = pulse_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg  <= 1'b0;
            prev_b_reg  <= 1'b0;
            primed_reg  <= 1'b0;
            armed_a_reg <= 1'b0;
            armed_b_reg <= 1'b0;
            pulse_reg   <= '0;
            tick_reg    <= '0;
        end
        else if (beat)
        begin
            prev_a_reg  <= prev_a_next;
            prev_b_reg  <= prev_b_next;
            primed_reg  <= primed_next;
            armed_a_reg <= armed_a_next;
            armed_b_reg <= armed_b_next;
            pulse_reg   <= pulse_next;
            tick_reg    <= tick_next;
        end
    end
endmodule
`default_nettype wire

[src/eps_queue.sv]
// Short queue of closed-window pulse counts between front and back.
// Depends on eps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eps_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire eps_pkg::window_beat_t push,
    input  wire logic                  pop,
    output eps_pkg::queue_status_t     status
);
    import eps_pkg::*;

    count_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_reg, rd_reg;
    logic [QPTR_BITS:0]     fill_reg, fill_next;

    always_comb
    begin
        fill_next = fill_reg;
        if (push.valid && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push.valid)
            fill_next = fill_reg - 1'b1;
        status.full  = (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
        status.empty = (fill_reg == '0);
        status.head  = slot_reg[rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            slot_reg[wr_reg] <= push.pulses;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push.valid)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end
endmodule
`default_nettype wire

[src/eps_back.sv]
// Back part: pulse count times scale, saturation, rpm, output register.
// Depends on eps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eps_back
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire eps_pkg::queue_status_t   status,
    input  wire eps_pkg::scale_t          speed_scale,
    output logic                          pop,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [eps_pkg::PULSES_BITS-1:0] window_pulses,
    output logic [eps_pkg::RPS_BITS-1:0]    rev_per_sec,
    output logic [eps_pkg::RPM_BITS-1:0]    rev_per_min
);
    import eps_pkg::*;

    localparam logic [PROD_BITS-1:0]   RPS_LIMIT = PROD_BITS'({RPS_BITS{1'b1}});
    localparam logic [PROD_BITS+5:0]   RPM_LIMIT = (PROD_BITS+6)'({RPM_BITS{1'b1}});
    localparam logic [COUNT_BITS:0]    PULSES_LIMIT = (COUNT_BITS+1)'({PULSES_BITS{1'b1}});

    logic                    s1_valid_reg;
    count_t                  s1_pulses_reg;
    logic [PROD_BITS-1:0]    s1_prod_reg;
    logic                    out_valid_reg;
    logic [PULSES_BITS-1:0]  pulses_reg;
    logic [RPS_BITS-1:0]     rps_reg;
    logic [RPM_BITS-1:0]     rpm_reg;

    logic                    s2_free, s1_free;
    logic [PROD_BITS+5:0]    prod_x60;
    logic [PULSES_BITS-1:0]  pulses_next;
    logic [RPS_BITS-1:0]     rps_next;
    logic [RPM_BITS-1:0]     rpm_next;

    always_comb
    begin
        s2_free = !out_valid_reg || out_ready;
        s1_free = !s1_valid_reg || s2_free;
        pop     = !status.empty && s1_free;

        // times 60 as times 64 minus times 4
        prod_x60 = {s1_prod_reg, 6'b0} - {4'b0, s1_prod_reg, 2'b0};
        rps_next = (s1_prod_reg > RPS_LIMIT) ? {RPS_BITS{1'b1}} : s1_prod_reg[RPS_BITS-1:0];
        rpm_next = (prod_x60 > RPM_LIMIT) ? {RPM_BITS{1'b1}} : prod_x60[RPM_BITS-1:0];
        pulses_next = ({1'b0, s1_pulses_reg} > PULSES_LIMIT) ? {PULSES_BITS{1'b1}}
                                                            : s1_pulses_reg[PULSES_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_pulses_reg <= status.head;
            s1_prod_reg   <= PROD_BITS'(status.head) * PROD_BITS'(speed_scale);
        end
        if (s1_valid_reg && s2_free)
        begin
            pulses_reg <= pulses_next;
            rps_reg    <= rps_next;
            rpm_reg    <= rpm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= pop;
            if (s2_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_pulses = pulses_reg;
    assign rev_per_sec   = rps_reg;
    assign rev_per_min   = rpm_reg;
endmodule
`default_nettype wire

[src/encoder_pulse_speed_meter.sv]
// Top level of the encoder pulse speed meter: APB registers and the three parts.
// Depends on eps_pkg, eps_if, eps_front, eps_queue and eps_back.
//
// Use: feed one sample of encoder phases A and B per beat on the sample channel
// (valid/ready). Phase A counts a pulse on a falling edge after a rising one,
// phase B on a rising edge after a falling one. After window_ticks samples the
// block sends one beat on the result channel: the window's pulse count, and the
// speed as saturated unsigned values, rev/s in Q16.16 and rev/min in Q24.16.
// Throughput: one sample per cycle while the queue is not full. The front part
// is a single register stage that closes the window; closed counts wait in a
// 4-entry queue. A result passes from the sample that closes its window through
// a queue slot, the registered 16x32 multiply and the saturating output register.
// Reset: counters, arming, previous levels and the queue clear; window_ticks
// returns to 33000 and speed_scale to 1612. The first sample only primes levels.
// Stall: when the receiver holds ready low, the output register holds its beat,
// the multiply stage and the queue fill, and sample ready drops only once the
// queue is full. Write registers only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module encoder_pulse_speed_meter
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    eps_sample_if.sink                               sample,
    eps_result_if.source                             result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [eps_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  wire logic [eps_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [eps_pkg::CFG_DATA_BITS-1:0]        prdata,
    output logic                                     pready
);
    import eps_pkg::*;

    window_t       window_ticks_reg;
    scale_t        speed_scale_reg;
    window_beat_t  push;
    queue_status_t status;
    logic          pop;
    logic          beat;
    reg_index_t    index;

    // register i sits at byte address 4*i
    assign index  = reg_index_t'(paddr[2]);
    assign pready = 1'b1;

    always_comb
    begin
        case (index)
            REG_WINDOW_TICKS: prdata = CFG_DATA_BITS'(window_ticks_reg);
            REG_SPEED_SCALE:  prdata = CFG_DATA_BITS'(speed_scale_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= WINDOW_BITS'(33000);
            speed_scale_reg  <= SCALE_BITS'(1612);
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (index)
                REG_WINDOW_TICKS: window_ticks_reg <= pwdata[WINDOW_BITS-1:0];
                REG_SPEED_SCALE:  speed_scale_reg  <= pwdata[SCALE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // accept a sample whenever the queue has room for a possible window close
    assign sample.ready = !status.full;
    assign beat         = sample.valid && !status.full;

    eps_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (beat),
        .level_a      (sample.level_a),
        .level_b      (sample.level_b),
        .window_ticks (window_ticks_reg),
        .push         (push)
    );

    eps_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (status)
    );

    eps_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .status        (status),
        .speed_scale   (speed_scale_reg),
        .pop           (pop),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .window_pulses (result.window_pulses),
        .rev_per_sec   (result.rev_per_sec),
        .rev_per_min   (result.rev_per_min)
    );
endmodule
`default_nettype wire
